>>> rtl/core/oidlog_pkg.sv
// Shared types and constants for the ordered ID log table.
// Holds command and result codes and the controller/datapath handshake structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package oidlog_pkg;

  localparam int unsigned TableDepthDef = 1024;

  localparam int unsigned IdW     = 64;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned LenW    = 11;
  localparam int unsigned IdxW    = 10;
  localparam int unsigned StatW   = 2;

  typedef enum logic [CmdW-1:0] {
    CmdAppend     = 3'd0,
    CmdDelete     = 3'd1,
    CmdTrimMaxlen = 3'd2,
    CmdTrimMinid  = 3'd3,
    CmdLowerBound = 3'd4,
    CmdReadAt     = 3'd5
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    RsOk         = 2'd0,
    RsNotGreater = 2'd1,
    RsFull       = 2'd2,
    RsNotFound   = 2'd3
  } rstat_e;

  // Datapath steps issued by the controller.
  typedef struct packed {
    logic load;
    logic srch_rd;
    logic srch_upd;
    logic lb_done;
    logic rd_lo;
    logic not_found;
    logic minid_set;
    logic append;
    logic maxlen;
    logic rd_n1;
    logic note_trim;
    logic dchk_ok;
    logic sh_rd;
    logic sh_wr;
    logic sh_end;
    logic rd_idx;
    logic cap_entry;
    logic resp;
  } op_t;

  // Conditions reported back to the controller.
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            lo_lt_hi;
    logic            lo_ge_count;
    logic            n_zero;
    logic            key_match;
    logic            sh_more;
    logic            idx_ge_count;
    logic            out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/core/ordered_id_log_table_unit.sv
// Top level of the ordered ID log table: stream ports, controller and datapath.
// Depends on oidlog_pkg, oidlog_ctrl and oidlog_dp.
// lower_bound, trim_minid and delete run a binary search of at most ceil(log2(entries+1))
// steps; delete then shifts each entry behind the deleted one down by one place.
// Throughput: one request at a time. Reset clears the table, the last and largest deleted IDs and the append count.
`timescale 1ns / 1ps
`default_nettype none

module ordered_id_log_table_unit #(
  parameter int unsigned TableDepth = oidlog_pkg::TableDepthDef
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // Bits up from 0: id_time, id_sequence, keep_length, remove_limit, entry_index.
  input  wire  [159:0] s_axis_tdata,
  // Bits up from 0: command.
  input  wire  [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // Bits up from 0: result_count, table_length, entry_time, entry_sequence,
  // deleted_time, deleted_sequence, appended_total, two zero bits.
  output logic [343:0] m_axis_tdata,
  // Bits up from 0: status.
  output logic [1:0]   m_axis_tuser
);
  import oidlog_pkg::*;

  op_t   op;
  stat_t st;

  logic [LenW-1:0] res_count, tab_len;
  logic [IdW-1:0]  e_time, e_seq, d_time, d_seq, app_tot;

  // The controller steps through search, trim and shift phases; the datapath
  // owns every stored value and only acts on the step it is told to take.
  oidlog_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .stat_i      (st),
    .op_o        (op)
  );

  oidlog_dp #(
    .TableDepth (TableDepth)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .op_i               (op),
    .stat_o             (st),
    .cmd_i              (s_axis_tuser),
    .id_time_i          (s_axis_tdata[63:0]),
    .id_sequence_i      (s_axis_tdata[127:64]),
    .keep_length_i      (s_axis_tdata[138:128]),
    .remove_limit_i     (s_axis_tdata[149:139]),
    .entry_index_i      (s_axis_tdata[159:150]),
    .out_ready_i        (m_axis_tready),
    .out_valid_o        (m_axis_tvalid),
    .status_o           (m_axis_tuser),
    .result_count_o     (res_count),
    .table_length_o     (tab_len),
    .entry_time_o       (e_time),
    .entry_sequence_o   (e_seq),
    .deleted_time_o     (d_time),
    .deleted_sequence_o (d_seq),
    .appended_total_o   (app_tot)
  );

  // The result register holds its value while the consumer stalls, so the
  // packed word is stable for the whole wait.
  assign m_axis_tdata = {2'b00, app_tot, d_seq, d_time, e_seq, e_time, tab_len, res_count};

endmodule

`default_nettype wire

>>> rtl/core/oidlog_ctrl.sv
// Controller state machine of the ordered ID log table.
// Depends on oidlog_pkg; drives the step commands of oidlog_dp.
`timescale 1ns / 1ps
`default_nettype none

module oidlog_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 req_valid_i,
  output logic                req_ready_o,
  input  oidlog_pkg::stat_t   stat_i,
  output oidlog_pkg::op_t     op_o
);
  import oidlog_pkg::*;

  typedef enum logic [13:0] {
    SIdle = 14'b00000000000001,
    SDisp = 14'b00000000000010,
    SSrch = 14'b00000000000100,
    SScmp = 14'b00000000001000,
    SPost = 14'b00000000010000,
    SExec = 14'b00000000100000,
    STrim = 14'b00000001000000,
    SNote = 14'b00000010000000,
    SDchk = 14'b00000100000000,
    SShr  = 14'b00001000000000,
    SShw  = 14'b00010000000000,
    SRdi  = 14'b00100000000000,
    SRdw  = 14'b01000000000000,
    SResp = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  assign req_ready_o = (state_q == SIdle);

  always_comb begin
    state_d = state_q;
    op_o    = '0;
    case (state_q)
      SIdle: begin
        if (req_valid_i) begin
          op_o.load = 1'b1;
          state_d   = SDisp;
        end
      end
      SDisp: begin
        case (stat_i.cmd)
          CmdAppend, CmdTrimMaxlen:              state_d = SExec;
          CmdDelete, CmdTrimMinid, CmdLowerBound: state_d = SSrch;
          CmdReadAt:                             state_d = SRdi;
          default:                               state_d = SResp;
        endcase
      end
      SSrch: begin
        if (stat_i.lo_lt_hi) begin
          op_o.srch_rd = 1'b1;
          state_d      = SScmp;
        end else begin
          state_d = SPost;
        end
      end
      SScmp: begin
        op_o.srch_upd = 1'b1;
        state_d       = SSrch;
      end
      SPost: begin
        case (stat_i.cmd)
          CmdLowerBound: begin
            op_o.lb_done = 1'b1;
            state_d      = SResp;
          end
          CmdDelete: begin
            if (stat_i.lo_ge_count) begin
              op_o.not_found = 1'b1;
              state_d        = SResp;
            end else begin
              op_o.rd_lo = 1'b1;
              state_d    = SDchk;
            end
          end
          CmdTrimMinid: begin
            op_o.minid_set = 1'b1;
            state_d        = STrim;
          end
          default: state_d = SResp;
        endcase
      end
      SExec: begin
        if (stat_i.cmd == CmdAppend) begin
          op_o.append = 1'b1;
          state_d     = SResp;
        end else begin
          op_o.maxlen = 1'b1;
          state_d     = STrim;
        end
      end
      STrim: begin
        if (stat_i.n_zero) begin
          state_d = SResp;
        end else begin
          op_o.rd_n1 = 1'b1;
          state_d    = SNote;
        end
      end
      SNote: begin
        op_o.note_trim = 1'b1;
        state_d        = SResp;
      end
      SDchk: begin
        if (stat_i.key_match) begin
          op_o.dchk_ok = 1'b1;
          state_d      = SShr;
        end else begin
          op_o.not_found = 1'b1;
          state_d        = SResp;
        end
      end
      SShr: begin
        if (stat_i.sh_more) begin
          op_o.sh_rd = 1'b1;
          state_d    = SShw;
        end else begin
          op_o.sh_end = 1'b1;
          state_d     = SResp;
        end
      end
      SShw: begin
        op_o.sh_wr = 1'b1;
        state_d    = SShr;
      end
      SRdi: begin
        if (stat_i.idx_ge_count) begin
          op_o.not_found = 1'b1;
          state_d        = SResp;
        end else begin
          op_o.rd_idx = 1'b1;
          state_d     = SRdw;
        end
      end
      SRdw: begin
        op_o.cap_entry = 1'b1;
        state_d        = SResp;
      end
      SResp: begin
        if (stat_i.out_free) begin
          op_o.resp = 1'b1;
          state_d   = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/oidlog_dp.sv
// Datapath of the ordered ID log table: entry memory as a ring, search
// counters, tracked IDs and the result register. Depends on oidlog_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oidlog_dp #(
  parameter int unsigned TableDepth = oidlog_pkg::TableDepthDef
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  oidlog_pkg::op_t                     op_i,
  output oidlog_pkg::stat_t                   stat_o,
  input  wire [oidlog_pkg::CmdW-1:0]          cmd_i,
  input  wire [oidlog_pkg::IdW-1:0]           id_time_i,
  input  wire [oidlog_pkg::IdW-1:0]           id_sequence_i,
  input  wire [oidlog_pkg::LenW-1:0]          keep_length_i,
  input  wire [oidlog_pkg::LenW-1:0]          remove_limit_i,
  input  wire [oidlog_pkg::IdxW-1:0]          entry_index_i,
  input  wire                                 out_ready_i,
  output logic                                out_valid_o,
  output logic [oidlog_pkg::StatW-1:0]        status_o,
  output logic [oidlog_pkg::LenW-1:0]         result_count_o,
  output logic [oidlog_pkg::LenW-1:0]         table_length_o,
  output logic [oidlog_pkg::IdW-1:0]          entry_time_o,
  output logic [oidlog_pkg::IdW-1:0]          entry_sequence_o,
  output logic [oidlog_pkg::IdW-1:0]          deleted_time_o,
  output logic [oidlog_pkg::IdW-1:0]          deleted_sequence_o,
  output logic [oidlog_pkg::IdW-1:0]          appended_total_o
);
  import oidlog_pkg::*;

  localparam int unsigned CW = $clog2(TableDepth + 1);
  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned XW = (CW > LenW) ? CW : LenW;
  localparam int unsigned EW = 2 * IdW;

  logic [EW-1:0] mem [TableDepth];

  logic [CmdW-1:0] cmd_q;
  logic [EW-1:0]   key_q;
  logic [LenW-1:0] keep_q, limit_q;
  logic [IdxW-1:0] idx_q;

  logic [AW-1:0]   head_q;
  logic [CW-1:0]   count_q;
  logic [EW-1:0]   last_q, maxdel_q;
  logic [IdW-1:0]  appcnt_q;

  logic [CW-1:0]   lo_q, hi_q, mid_q, ptr_q, n_q;
  logic [EW-1:0]   rdata_q;

  logic [StatW-1:0] res_stat_q;
  logic [CW-1:0]    res_cnt_q;
  logic [EW-1:0]    res_ent_q;
  logic             out_valid_q;

  // Logical position to ring address; the sum stays below twice the depth.
  function automatic logic [AW-1:0] phys(input logic [XW-1:0] l);
    logic [XW:0] s;
    begin
      s = (XW+1)'(head_q) + {1'b0, l};
      if (s >= (XW+1)'(TableDepth)) s = s - (XW+1)'(TableDepth);
      return s[AW-1:0];
    end
  endfunction

  logic [CW:0]   lohi_sum;
  logic [CW-1:0] mid_d;
  logic [CW:0]   ptr_inc;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;
  logic [XW-1:0] cnt_x, keep_x, lim_x, diff_x, trim_x, minid_x;

  assign lohi_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_d    = lohi_sum[CW:1];
  assign ptr_inc  = {1'b0, ptr_q} + (CW+1)'(1);

  assign cnt_x   = XW'(count_q);
  assign keep_x  = XW'(keep_q);
  assign lim_x   = XW'(limit_q);
  assign diff_x  = (keep_x >= cnt_x) ? '0 : cnt_x - keep_x;
  assign trim_x  = (lim_x < diff_x) ? lim_x : diff_x;
  assign minid_x = (lim_x < XW'(lo_q)) ? lim_x : XW'(lo_q);

  always_comb begin
    rd_en   = op_i.srch_rd | op_i.rd_lo | op_i.rd_n1 | op_i.sh_rd | op_i.rd_idx;
    rd_addr = phys(XW'(mid_d));
    if (op_i.rd_lo)  rd_addr = phys(XW'(lo_q));
    if (op_i.rd_n1)  rd_addr = phys(XW'(n_q) - XW'(1));
    if (op_i.sh_rd)  rd_addr = phys(XW'(ptr_inc));
    if (op_i.rd_idx) rd_addr = phys(XW'(idx_q));
  end

  always_comb begin
    wr_en   = op_i.sh_wr;
    wr_addr = phys(XW'(ptr_q));
    wr_data = rdata_q;
    if (op_i.append && (last_q < key_q) && (count_q < CW'(TableDepth))) begin
      wr_en   = 1'b1;
      wr_addr = phys(cnt_x);
      wr_data = key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  // Command fields and per-command scratch values.
  always_ff @(posedge clk_i) begin
    if (op_i.load) begin
      cmd_q   <= cmd_i;
      key_q   <= {id_time_i, id_sequence_i};
      keep_q  <= keep_length_i;
      limit_q <= remove_limit_i;
      idx_q   <= entry_index_i;
    end
    if (op_i.srch_rd) mid_q <= mid_d;
    if (op_i.maxlen)    n_q <= CW'(trim_x);
    if (op_i.minid_set) n_q <= CW'(minid_x);
    if (op_i.dchk_ok)   ptr_q <= lo_q;
    if (op_i.sh_wr)     ptr_q <= ptr_inc[CW-1:0];
    if (op_i.cap_entry) res_ent_q <= rdata_q;
    if (op_i.load) begin
      res_ent_q <= '0;
      res_cnt_q <= '0;
      res_stat_q <= RsOk;
    end
    if (op_i.lb_done)   res_cnt_q <= lo_q;
    if (op_i.maxlen)    res_cnt_q <= CW'(trim_x);
    if (op_i.minid_set) res_cnt_q <= CW'(minid_x);
    if (op_i.dchk_ok)   res_cnt_q <= CW'(1);
    if (op_i.not_found) res_stat_q <= RsNotFound;
    if (op_i.append) begin
      if (!(last_q < key_q)) begin
        res_stat_q <= RsNotGreater;
      end else if (count_q >= CW'(TableDepth)) begin
        res_stat_q <= RsFull;
      end
    end
  end

  // Table state and binary search bounds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      last_q   <= '0;
      maxdel_q <= '0;
      appcnt_q <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
    end else begin
      if (op_i.load) begin
        lo_q <= '0;
        hi_q <= count_q;
      end
      if (op_i.srch_upd) begin
        if (rdata_q < key_q) begin
          lo_q <= mid_q + CW'(1);
        end else begin
          hi_q <= mid_q;
        end
      end
      if (op_i.append && (last_q < key_q) && (count_q < CW'(TableDepth))) begin
        count_q  <= count_q + CW'(1);
        last_q   <= key_q;
        appcnt_q <= appcnt_q + IdW'(1);
      end
      if ((op_i.note_trim || op_i.dchk_ok) && (maxdel_q < rdata_q)) begin
        maxdel_q <= rdata_q;
      end
      if (op_i.note_trim) begin
        head_q  <= phys(XW'(n_q));
        count_q <= count_q - n_q;
      end
      if (op_i.sh_end) count_q <= count_q - CW'(1);
    end
  end

  // Result register; a finished result waits here for the consumer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i.resp) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.resp) begin
      status_o           <= res_stat_q;
      result_count_o     <= LenW'(res_cnt_q);
      table_length_o     <= LenW'(count_q);
      entry_time_o       <= res_ent_q[EW-1:IdW];
      entry_sequence_o   <= res_ent_q[IdW-1:0];
      deleted_time_o     <= maxdel_q[EW-1:IdW];
      deleted_sequence_o <= maxdel_q[IdW-1:0];
      appended_total_o   <= appcnt_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    stat_o              = '0;
    stat_o.cmd          = cmd_q;
    stat_o.lo_lt_hi     = lo_q < hi_q;
    stat_o.lo_ge_count  = lo_q >= count_q;
    stat_o.n_zero       = (n_q == '0);
    stat_o.key_match    = (rdata_q == key_q);
    stat_o.sh_more      = ptr_inc < {1'b0, count_q};
    stat_o.idx_ge_count = XW'(idx_q) >= cnt_x;
    stat_o.out_free     = !out_valid_q || out_ready_i;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TableDepth))
    else $error("entry count beyond table depth");

  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q <= hi_q)
    else $error("search bounds crossed");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(op_i.resp))
    else $error("result shown without a response step");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i.append && (last_q < key_q) && (count_q < CW'(TableDepth)))
      |=> (count_q == $past(count_q) + CW'(1)))
    else $error("append did not grow the table");

endmodule

`default_nettype wire
